// ----- rtl/hsvsky_pkg.sv -----
// shared constants, types and widths of the hsv to rgb sky colour converter
`default_nettype none

package hsvsky_pkg;

  // hue is carried internally as an unsigned fraction of a turn of this many bits
  localparam int HueBits = 16;

  localparam int FieldW = 16;
  localparam int ChanW  = 8;
  localparam int SectW  = 3;

  // number of register stages between an input beat and its result
  localparam int PipeDepth = 7;

  localparam logic [FieldW-1:0] Q15One = FieldW'(32768);

  // temperature clamp, q3.12 of plus or minus 3.0
  localparam int TempLimit = 12288;
  localparam int TempW     = 15;
  localparam logic signed [FieldW-1:0] TempHi = FieldW'(TempLimit);
  localparam logic signed [FieldW-1:0] TempLo = FieldW'(-TempLimit);

  // sky hue: m = (((458752 - 3t) << HueBits) + 368640) >> 14, hue = m / 45
  localparam int SkyHnW    = 19;
  localparam int SkyHnOff  = 458752;
  localparam int SkyHRound = 368640;
  localparam int SkyHShift = 14;
  localparam int SkyHDiv   = 45;
  localparam int SkyNW     = SkyHnW + HueBits + 1;
  localparam int SkyMW     = SkyNW - SkyHShift;
  localparam int SkyHKW    = SkyMW - 5;
  localparam logic signed [SkyHnW:0] SkyHnOffS = (SkyHnW + 1)'(SkyHnOff);
  localparam logic [SkyHKW-1:0] SkyHRecip = SkyHKW'((64'd1 << SkyMW) / SkyHDiv);

  // sky saturation: xs = (491535 + 8t) >> 1, saturation = xs / 15
  localparam int SkySOff = 491535;
  localparam int SkyXW   = 20;
  localparam int SkySW   = SkyXW - 1;
  localparam int SkySDiv = 15;
  localparam int SkySKW  = SkySW - 3;
  localparam logic signed [SkyXW:0] SkySOffS = (SkyXW + 1)'(SkySOff);
  localparam logic [SkySKW-1:0] SkySRecip = SkySKW'((64'd1 << SkySW) / SkySDiv);

  // six-sector conversion widths
  localparam int FullW     = FieldW + HueBits;
  localparam int ProdW     = 2 * FieldW - 1 + HueBits;
  localparam int ChanShift = ProdW - 1;
  localparam int ScaleW    = ProdW + ChanW;

  typedef enum logic {
    OpHsv = 1'b0,
    OpSky = 1'b1
  } op_e;

  typedef struct packed {
    op_e               opcode;
    logic [FieldW-1:0] hue;
    logic [FieldW-1:0] saturation;
    logic [FieldW-1:0] brightness;
    logic [FieldW-1:0] temperature;
  } req_t;

  typedef struct packed {
    logic               valid;
    logic [HueBits-1:0] hue;
    logic [FieldW-1:0]  saturation;
    logic [FieldW-1:0]  brightness;
  } hsv_beat_t;

endpackage

`default_nettype wire

// ----- rtl/hsvsky_if.sv -----
// request and response channel interfaces of the hsv to rgb sky colour converter
`default_nettype none

interface hsvsky_req_if;
  logic                             valid;
  logic                             ready;
  logic                             opcode;
  logic [hsvsky_pkg::FieldW-1:0]    hue;
  logic [hsvsky_pkg::FieldW-1:0]    saturation;
  logic [hsvsky_pkg::FieldW-1:0]    brightness;
  logic signed [hsvsky_pkg::FieldW-1:0] temperature;

  modport source (output valid, opcode, hue, saturation, brightness, temperature,
                  input ready);
  modport sink (input valid, opcode, hue, saturation, brightness, temperature,
                output ready);
endinterface

interface hsvsky_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [hsvsky_pkg::ChanW-1:0] red;
  logic [hsvsky_pkg::ChanW-1:0] green;
  logic [hsvsky_pkg::ChanW-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

// ----- rtl/hsv_to_rgb_sky_color.sv -----
// hsv to rgb colour converter with a temperature to sky colour front end
//
// req_i takes one beat per cycle while req_i.ready is high: opcode, hue
// (q0.16), saturation and brightness (q1.15, held to 1.0) and a signed q3.12
// temperature. opcode 0 converts the given hue, saturation and brightness;
// opcode 1 derives them from the temperature first. rsp_o returns red, green
// and blue, one beat for every request beat, in order.
// There are seven register stages: a, b and c in hsvsky_front, then d, e, f
// and g here; rsp_o is driven from stage g.
// Throughput is one beat every cycle while nothing stalls; the reciprocal
// dividers and the brightness multipliers each have a stage of their own.
// Reset clears the valid bit of every stage; data registers are not reset.
// When the receiver holds rsp_o.ready low the result stays on rsp_o and the
// stages behind it keep filling until each holds a beat; only then does
// req_i.ready fall. No beat is dropped or repeated.
`default_nettype none

module hsv_to_rgb_sky_color (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  hsvsky_req_if.sink          req_i,
  hsvsky_rsp_if.source        rsp_o
);

  localparam int HB = hsvsky_pkg::HueBits;
  localparam int FW = hsvsky_pkg::FieldW;
  localparam int PW = hsvsky_pkg::ProdW;
  localparam int XW = hsvsky_pkg::FullW;
  localparam int SW = hsvsky_pkg::ScaleW;
  localparam int CW = hsvsky_pkg::ChanW;

  typedef enum logic [hsvsky_pkg::SectW-1:0] {
    SecRedYellow   = 3'd0,
    SecYellowGreen = 3'd1,
    SecGreenCyan   = 3'd2,
    SecCyanBlue    = 3'd3,
    SecBlueMagenta = 3'd4
  } sector_e;

  hsvsky_pkg::req_t      req;
  hsvsky_pkg::hsv_beat_t hsv;
  logic                  hsv_ready;

  logic d_valid_q, e_valid_q, f_valid_q, g_valid_q;
  logic en_d, en_e, en_f, en_g;

  sector_e         d_sec_q, e_sec_q, f_sec_q;
  logic [HB-1:0]   d_f_q;
  logic [FW-1:0]   d_sat_q, d_bri_q;
  logic [XW-1:0]   e_pf_q, e_pt_q;
  logic [FW-1:0]   e_pp_q, e_bri_q;
  logic [PW-1:0]   f_vb_q, f_vp_q, f_vq_q, f_vt_q;
  logic [CW-1:0]   g_red_q, g_green_q, g_blue_q;

  logic [HB+2:0]   h6;
  logic [HB:0]     one_minus_f;
  logic [XW:0]     pt_wide;
  logic [XW-1:0]   full, qm, tm;
  logic [PW-1:0]   r_sel, g_sel, b_sel;
  logic [SW-1:0]   r_sc, g_sc, b_sc;

  assign req.opcode      = hsvsky_pkg::op_e'(req_i.opcode);
  assign req.hue         = req_i.hue;
  assign req.saturation  = req_i.saturation;
  assign req.brightness  = req_i.brightness;
  assign req.temperature = req_i.temperature;

  hsvsky_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_i       (req),
    .req_ready_o (req_i.ready),
    .hsv_o       (hsv),
    .hsv_ready_i (hsv_ready)
  );

  assign en_g      = !g_valid_q || rsp_o.ready;
  assign en_f      = !f_valid_q || en_g;
  assign en_e      = !e_valid_q || en_f;
  assign en_d      = !d_valid_q || en_e;
  assign hsv_ready = en_d;

  // sector and fraction from hue * 6
  assign h6 = {2'b00, hsv.hue, 1'b0} + {1'b0, hsv.hue, 2'b00};

  assign one_minus_f = {1'b1, {HB{1'b0}}} - {1'b0, d_f_q};
  assign pt_wide     = (XW+1)'(d_sat_q) * (XW+1)'(one_minus_f);

  assign full = {hsvsky_pkg::Q15One, {HB{1'b0}}};
  assign qm   = full - e_pf_q;
  assign tm   = full - e_pt_q;

  always_comb begin
    unique case (f_sec_q)
      SecRedYellow: begin
        r_sel = f_vb_q; g_sel = f_vt_q; b_sel = f_vp_q;
      end
      SecYellowGreen: begin
        r_sel = f_vq_q; g_sel = f_vb_q; b_sel = f_vp_q;
      end
      SecGreenCyan: begin
        r_sel = f_vp_q; g_sel = f_vb_q; b_sel = f_vt_q;
      end
      SecCyanBlue: begin
        r_sel = f_vp_q; g_sel = f_vq_q; b_sel = f_vb_q;
      end
      SecBlueMagenta: begin
        r_sel = f_vt_q; g_sel = f_vp_q; b_sel = f_vb_q;
      end
      default: begin
        // magenta to red
        r_sel = f_vb_q; g_sel = f_vp_q; b_sel = f_vq_q;
      end
    endcase
    // x * 255 plus half an lsb of the channel
    r_sc = ({r_sel, {CW{1'b0}}} - SW'(r_sel)) + (SW'(1) << (hsvsky_pkg::ChanShift - 1));
    g_sc = ({g_sel, {CW{1'b0}}} - SW'(g_sel)) + (SW'(1) << (hsvsky_pkg::ChanShift - 1));
    b_sc = ({b_sel, {CW{1'b0}}} - SW'(b_sel)) + (SW'(1) << (hsvsky_pkg::ChanShift - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
      e_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
      g_valid_q <= 1'b0;
    end else begin
      if (en_d) d_valid_q <= hsv.valid;
      if (en_e) e_valid_q <= d_valid_q;
      if (en_f) f_valid_q <= e_valid_q;
      if (en_g) g_valid_q <= f_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d && hsv.valid) begin
      d_sec_q <= sector_e'(h6[HB+2:HB]);
      d_f_q   <= h6[HB-1:0];
      d_sat_q <= hsv.saturation;
      d_bri_q <= hsv.brightness;
    end
    if (en_e && d_valid_q) begin
      e_sec_q <= d_sec_q;
      e_pf_q  <= XW'(d_sat_q) * XW'(d_f_q);
      e_pt_q  <= pt_wide[XW-1:0];
      e_pp_q  <= hsvsky_pkg::Q15One - d_sat_q;
      e_bri_q <= d_bri_q;
    end
    if (en_f && e_valid_q) begin
      f_sec_q <= e_sec_q;
      f_vb_q  <= {e_bri_q, {(PW-FW){1'b0}}};
      f_vp_q  <= PW'(e_bri_q) * PW'({e_pp_q, {HB{1'b0}}});
      f_vq_q  <= PW'(e_bri_q) * PW'(qm);
      f_vt_q  <= PW'(e_bri_q) * PW'(tm);
    end
    if (en_g && f_valid_q) begin
      g_red_q   <= r_sc[hsvsky_pkg::ChanShift +: CW];
      g_green_q <= g_sc[hsvsky_pkg::ChanShift +: CW];
      g_blue_q  <= b_sc[hsvsky_pkg::ChanShift +: CW];
    end
  end

  assign rsp_o.valid = g_valid_q;
  assign rsp_o.red   = g_red_q;
  assign rsp_o.green = g_green_q;
  assign rsp_o.blue  = g_blue_q;

endmodule

`default_nettype wire

// ----- rtl/hsvsky_front.sv -----
// front end: input saturation, temperature to hue and saturation, three stages
`default_nettype none

module hsvsky_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    req_valid_i,
  input  hsvsky_pkg::req_t       req_i,
  output logic                   req_ready_o,
  output hsvsky_pkg::hsv_beat_t  hsv_o,
  input  wire                    hsv_ready_i
);

  localparam int HB = hsvsky_pkg::HueBits;
  localparam int FW = hsvsky_pkg::FieldW;
  localparam int MW = hsvsky_pkg::SkyMW;
  localparam int KH = hsvsky_pkg::SkyHKW;
  localparam int SW = hsvsky_pkg::SkySW;
  localparam int KS = hsvsky_pkg::SkySKW;

  logic a_valid_q, b_valid_q, c_valid_q;
  logic en_a, en_b, en_c;

  // stage a payload
  hsvsky_pkg::op_e a_op_q;
  logic [HB-1:0]   a_hue_q;
  logic [FW-1:0]   a_sat_q, a_bri_q;
  logic [MW-1:0]   a_m_q;
  logic [SW-1:0]   a_xs_q;

  // stage b payload
  hsvsky_pkg::op_e b_op_q;
  logic [HB-1:0]   b_hue_q;
  logic [FW-1:0]   b_sat_q, b_bri_q;
  logic [MW-1:0]   b_m_q;
  logic [SW-1:0]   b_xs_q;
  logic [KH-1:0]   b_qh_q;
  logic [KS-1:0]   b_qs_q;

  // stage c payload
  logic [HB-1:0]   c_hue_q;
  logic [FW-1:0]   c_sat_q, c_bri_q;

  // stage a logic
  logic [FW+HB-1:0]                      hue_wide;
  logic [HB-1:0]                         hue_h;
  logic [FW-1:0]                         sat_in, bri_in;
  logic signed [FW-1:0]                  t_raw;
  logic signed [hsvsky_pkg::TempW-1:0]   t_c;
  logic signed [hsvsky_pkg::SkyHnW:0]    t_w, hn_s;
  logic signed [hsvsky_pkg::SkyXW:0]     t_x, x_s;
  logic [hsvsky_pkg::SkyNW-1:0]          n_h;

  // stage b and c logic
  logic [MW+KH-1:0] prod_h;
  logic [SW+KS-1:0] prod_s;
  logic [MW-1:0]    rem_h;
  logic [SW-1:0]    rem_s;
  logic [KH-1:0]    q_h;
  logic [KS-1:0]    q_s;

  assign en_c        = !c_valid_q || hsv_ready_i;
  assign en_b        = !b_valid_q || en_c;
  assign en_a        = !a_valid_q || en_b;
  assign req_ready_o = en_a;

  always_comb begin
    // hue rescale: top HueBits bits of the field followed by zeros
    hue_wide = {req_i.hue, {HB{1'b0}}};
    hue_h    = hue_wide[FW+HB-1 -: HB];
    sat_in   = (req_i.saturation > hsvsky_pkg::Q15One) ? hsvsky_pkg::Q15One
                                                       : req_i.saturation;
    bri_in   = (req_i.brightness > hsvsky_pkg::Q15One) ? hsvsky_pkg::Q15One
                                                       : req_i.brightness;

    t_raw = $signed(req_i.temperature);
    if (t_raw > hsvsky_pkg::TempHi) begin
      t_c = hsvsky_pkg::TempW'(hsvsky_pkg::TempHi);
    end else if (t_raw < hsvsky_pkg::TempLo) begin
      t_c = hsvsky_pkg::TempW'(hsvsky_pkg::TempLo);
    end else begin
      t_c = hsvsky_pkg::TempW'(t_raw);
    end

    t_w  = (hsvsky_pkg::SkyHnW + 1)'(t_c);
    hn_s = hsvsky_pkg::SkyHnOffS - (t_w + (t_w <<< 1));
    n_h  = {1'b0, hn_s[hsvsky_pkg::SkyHnW-1:0], {HB{1'b0}}}
           + hsvsky_pkg::SkyNW'(hsvsky_pkg::SkyHRound);

    t_x = (hsvsky_pkg::SkyXW + 1)'(t_c);
    x_s = hsvsky_pkg::SkySOffS + (t_x <<< 3);
  end

  // reciprocal estimates, low by at most one
  assign prod_h = (MW+KH)'(a_m_q) * (MW+KH)'(hsvsky_pkg::SkyHRecip);
  assign prod_s = (SW+KS)'(a_xs_q) * (SW+KS)'(hsvsky_pkg::SkySRecip);

  always_comb begin
    rem_h = b_m_q - MW'(b_qh_q) * MW'(hsvsky_pkg::SkyHDiv);
    rem_s = b_xs_q - SW'(b_qs_q) * SW'(hsvsky_pkg::SkySDiv);
    q_h   = (rem_h >= MW'(hsvsky_pkg::SkyHDiv)) ? b_qh_q + KH'(1) : b_qh_q;
    q_s   = (rem_s >= SW'(hsvsky_pkg::SkySDiv)) ? b_qs_q + KS'(1) : b_qs_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (en_a) a_valid_q <= req_valid_i;
      if (en_b) b_valid_q <= a_valid_q;
      if (en_c) c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a && req_valid_i) begin
      a_op_q  <= req_i.opcode;
      a_hue_q <= hue_h;
      a_sat_q <= sat_in;
      a_bri_q <= bri_in;
      a_m_q   <= n_h[hsvsky_pkg::SkyNW-1:hsvsky_pkg::SkyHShift];
      a_xs_q  <= x_s[SW:1];
    end
    if (en_b && a_valid_q) begin
      b_op_q  <= a_op_q;
      b_hue_q <= a_hue_q;
      b_sat_q <= a_sat_q;
      b_bri_q <= a_bri_q;
      b_m_q   <= a_m_q;
      b_xs_q  <= a_xs_q;
      b_qh_q  <= prod_h[MW+KH-1:MW];
      b_qs_q  <= prod_s[SW+KS-1:SW];
    end
    if (en_c && b_valid_q) begin
      unique case (b_op_q)
        hsvsky_pkg::OpHsv: begin
          c_hue_q <= b_hue_q;
          c_sat_q <= b_sat_q;
          c_bri_q <= b_bri_q;
        end
        hsvsky_pkg::OpSky: begin
          c_hue_q <= q_h[HB-1:0];
          c_sat_q <= FW'(q_s);
          c_bri_q <= hsvsky_pkg::Q15One;
        end
        default: begin
          c_hue_q <= b_hue_q;
          c_sat_q <= b_sat_q;
          c_bri_q <= b_bri_q;
        end
      endcase
    end
  end

  assign hsv_o.valid      = c_valid_q;
  assign hsv_o.hue        = c_hue_q;
  assign hsv_o.saturation = c_sat_q;
  assign hsv_o.brightness = c_bri_q;

endmodule

`default_nettype wire

// ----- rtl/hsvsky_chk.sv -----
// port checker of the hsv to rgb sky colour converter and its bind
`default_nettype none

module hsvsky_chk (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          req_valid_i,
  input wire                          req_ready_i,
  input wire                          req_opcode_i,
  input wire [hsvsky_pkg::FieldW-1:0] req_saturation_i,
  input wire                          rsp_valid_i,
  input wire                          rsp_ready_i,
  input wire [hsvsky_pkg::ChanW-1:0]  rsp_red_i,
  input wire [hsvsky_pkg::ChanW-1:0]  rsp_green_i,
  input wire [hsvsky_pkg::ChanW-1:0]  rsp_blue_i
);

  localparam int CntW = $clog2(hsvsky_pkg::PipeDepth + 1) + 1;

  logic            req_beat, rsp_beat, grey_beat;
  logic [CntW-1:0] inflight_q;

  assign req_beat  = req_valid_i && req_ready_i;
  assign rsp_beat  = rsp_valid_i && rsp_ready_i;
  assign grey_beat = req_beat && (req_opcode_i == hsvsky_pkg::OpHsv)
                     && (req_saturation_i == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + CntW'(req_beat) - CntW'(rsp_beat);
    end
  end

  // a stalled result beat holds its colour
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_red_i)
      && $stable(rsp_green_i) && $stable(rsp_blue_i))
    else $error("result beat changed while stalled");

  // no result beat without an outstanding request beat
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> inflight_q != '0)
    else $error("result beat with no request outstanding");

  // never more beats outstanding than there are stages
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= CntW'(hsvsky_pkg::PipeDepth))
    else $error("more beats outstanding than pipeline stages");

  // zero saturation comes out grey after the full latency when nothing stalls
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grey_beat ##1 rsp_ready_i ##1 rsp_ready_i ##1 rsp_ready_i ##1 rsp_ready_i
      ##1 rsp_ready_i ##1 rsp_ready_i
      |=> rsp_valid_i && rsp_red_i == rsp_green_i && rsp_green_i == rsp_blue_i)
    else $error("zero saturation did not give grey at full latency");

endmodule

bind hsv_to_rgb_sky_color hsvsky_chk u_hsvsky_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .req_opcode_i     (req_i.opcode),
  .req_saturation_i (req_i.saturation),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .rsp_red_i        (rsp_o.red),
  .rsp_green_i      (rsp_o.green),
  .rsp_blue_i       (rsp_o.blue)
);

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// self-checking testbench of the hsv to rgb sky colour converter
module testbench;
  import hsvsky_pkg::*;

  localparam int HalfPeriod  = 6;
  localparam int ResetCycles = 9;
  localparam int IdlePct     = 22;
  localparam int RandomBeats = 530;
  localparam int CalmFirst   = 200;
  localparam int CalmLast    = 330;
  localparam int StallLimit  = 4000;
  localparam int SkyHDen     = 737280;
  localparam int SkySBase    = 245760;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  typedef struct packed {
    op_e               opcode;
    logic [FieldW-1:0] hue;
    logic [FieldW-1:0] saturation;
    logic [FieldW-1:0] brightness;
    logic [FieldW-1:0] temperature;
    logic              typed;
    logic [ChanW-1:0]  red;
    logic [ChanW-1:0]  green;
    logic [ChanW-1:0]  blue;
  } dir_row_t;

  // typed rows carry their colour, the others go through convert_to_rgb
  dir_row_t dir_rows [23] = '{
    '{OpHsv, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 8'd0, 8'd0, 8'd0},
    '{OpHsv, 16'h0000, 16'h8000, 16'h8000, 16'h0000, 1'b1, 8'd255, 8'd0, 8'd0},
    '{OpHsv, 16'h0000, 16'h0000, 16'h8000, 16'h0000, 1'b1, 8'd255, 8'd255, 8'd255},
    '{OpHsv, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 1'b1, 8'd128, 8'd128, 8'd128},
    '{OpHsv, 16'h1234, 16'h0000, 16'hFFFF, 16'h0000, 1'b1, 8'd255, 8'd255, 8'd255},
    '{OpHsv, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b1, 8'd0, 8'd255, 8'd255},
    '{OpHsv, 16'h2AAA, 16'h8000, 16'h8000, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OpHsv, 16'h3000, 16'h8000, 16'h6000, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OpHsv, 16'h6000, 16'h5000, 16'h8000, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OpHsv, 16'hA000, 16'h8000, 16'h7FFF, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OpHsv, 16'hB000, 16'h4000, 16'h8000, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OpHsv, 16'hE000, 16'h8000, 16'h8000, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OpHsv, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OpHsv, 16'h5555, 16'h8001, 16'h8001, 16'h8000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OpSky, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OpSky, 16'h0000, 16'h0000, 16'h0000, 16'h3000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OpSky, 16'h0000, 16'h0000, 16'h0000, 16'hD000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OpSky, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OpSky, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OpSky, 16'h0000, 16'h0000, 16'h0000, 16'h3001, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OpSky, 16'h0000, 16'h0000, 16'h0000, 16'hCFFF, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OpSky, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 1'b0, 8'd0, 8'd0, 8'd0},
    '{OpSky, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1'b0, 8'd0, 8'd0, 8'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic calm;
  int   fail_count  = 0;
  int   idle_cycles = 0;
  rgb_t rgb_due_q [$];

  hsvsky_req_if req_bus ();
  hsvsky_rsp_if rsp_bus ();

  hsv_to_rgb_sky_color DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  always #(HalfPeriod) clk_i = ~clk_i;

  // exact numerator over 2^(30+hue bits), scaled to 255 and rounded half up
  function automatic logic [ChanW-1:0] channel_of(longint unsigned num);
    longint unsigned half;
    half = 64'd1 << (29 + HueBits);
    return ChanW'((num * 255 + half) >> (30 + HueBits));
  endfunction

  function automatic rgb_t convert_to_rgb(req_t item);
    longint unsigned h, s, b, one_h, h6, sector, f, full, vb, vp, vq, vt;
    int   t;
    rgb_t c;
    one_h = 64'd1 << HueBits;
    if (item.opcode == OpHsv) begin
      h = item.hue;
      h = (HueBits >= FieldW) ? (h << (HueBits - FieldW)) : (h >> (FieldW - HueBits));
      s = (item.saturation > Q15One) ? Q15One : item.saturation;
      b = (item.brightness > Q15One) ? Q15One : item.brightness;
    end else begin
      t = $signed(item.temperature);
      if (t > TempLimit) t = TempLimit;
      else if (t < -TempLimit) t = -TempLimit;
      h = ((longint'(SkyHnOff - 3 * t) << HueBits) + SkyHRound) / SkyHDen;
      s = (2 * (SkySBase + 4 * t) + 15) / 30;
      b = Q15One;
    end
    h6     = (h & (one_h - 1)) * 6;
    sector = h6 >> HueBits;
    f      = h6 & (one_h - 1);
    full   = Q15One;
    full   = full << HueBits;
    vb     = b * full;
    vp     = b * (full - (s << HueBits));
    vq     = b * (full - s * f);
    vt     = b * (full - s * (one_h - f));
    case (sector)
      0:       c = '{channel_of(vb), channel_of(vt), channel_of(vp)};
      1:       c = '{channel_of(vq), channel_of(vb), channel_of(vp)};
      2:       c = '{channel_of(vp), channel_of(vb), channel_of(vt)};
      3:       c = '{channel_of(vp), channel_of(vq), channel_of(vb)};
      4:       c = '{channel_of(vt), channel_of(vp), channel_of(vb)};
      default: c = '{channel_of(vb), channel_of(vp), channel_of(vq)};
    endcase
    return c;
  endfunction

  // q1.15 field: mostly in range, with the ends, the area round 1.0 and raw noise
  function automatic logic [FieldW-1:0] pick_q15();
    logic [FieldW-1:0] v;
    case ($urandom_range(9))
      6:       v = '0;
      7:       v = Q15One;
      8:       v = FieldW'($urandom_range(65535));
      9:       v = FieldW'($urandom_range(32780, 32756));
      default: v = FieldW'($urandom_range(32768));
    endcase
    return v;
  endfunction

  task automatic flag_colour(string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  task automatic send_beat(req_t item, rgb_t want);
    while (!calm && $urandom_range(99) < IdlePct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid       <= 1'b1;
    req_bus.opcode      <= item.opcode;
    req_bus.hue         <= item.hue;
    req_bus.saturation  <= item.saturation;
    req_bus.brightness  <= item.brightness;
    req_bus.temperature <= item.temperature;
    do @(posedge clk_i); while (!req_bus.ready);
    rgb_due_q.insert(rgb_due_q.size(), want);
  endtask

  task automatic hold_until_drained();
    req_bus.valid <= 1'b0;
    while (rgb_due_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    rsp_bus.ready <= calm || ($urandom_range(99) >= IdlePct);
  end

  always @(posedge clk_i) begin
    rgb_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (rgb_due_q.size() == 0) begin
        flag_colour($sformatf("unexpected beat %0d/%0d/%0d",
                              rsp_bus.red, rsp_bus.green, rsp_bus.blue));
      end else begin
        want = rgb_due_q.pop_front();
        if (rsp_bus.red !== want.red)
          flag_colour($sformatf("red %0d, want %0d", rsp_bus.red, want.red));
        if (rsp_bus.green !== want.green)
          flag_colour($sformatf("green %0d, want %0d", rsp_bus.green, want.green));
        if (rsp_bus.blue !== want.blue)
          flag_colour($sformatf("blue %0d, want %0d", rsp_bus.blue, want.blue));
      end
    end
  end

  // watchdog: too long without a beat on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    req_t item;
    rgb_t want;
    int   n;
    rst_ni              <= 1'b0;
    calm                <= 1'b0;
    req_bus.valid       <= 1'b0;
    req_bus.opcode      <= OpHsv;
    req_bus.hue         <= '0;
    req_bus.saturation  <= '0;
    req_bus.brightness  <= '0;
    req_bus.temperature <= '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      item = '{dir_rows[i].opcode, dir_rows[i].hue, dir_rows[i].saturation,
               dir_rows[i].brightness, dir_rows[i].temperature};
      if (dir_rows[i].typed)
        want = '{dir_rows[i].red, dir_rows[i].green, dir_rows[i].blue};
      else
        want = convert_to_rgb(item);
      send_beat(item, want);
    end
    hold_until_drained();

    for (n = 0; n < RandomBeats; n++) begin
      calm <= (n >= CalmFirst && n < CalmLast);
      item.opcode     = ($urandom_range(1) == 1) ? OpSky : OpHsv;
      item.hue        = FieldW'($urandom_range(65535));
      item.saturation = pick_q15();
      item.brightness = pick_q15();
      // mostly within plus or minus 3.0, sometimes anywhere
      if ($urandom_range(7) < 6)
        item.temperature = FieldW'(int'($urandom_range(2 * TempLimit)) - TempLimit);
      else
        item.temperature = FieldW'($urandom_range(65535));
      send_beat(item, convert_to_rgb(item));
      if (n == RandomBeats / 2) hold_until_drained();
    end
    calm <= 1'b0;
    hold_until_drained();
    repeat (3 * PipeDepth) @(posedge clk_i);

    if (fail_count == 0 && rgb_due_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
